// ===== src/fsgc_pkg.sv =====
// Shared types and codes for the flash segment garbage-collection manager.
package fsgc_pkg;

    localparam int PAGE_W = 16;
    localparam int THR_W  = 7;

    typedef enum logic [2:0] {
        ROLE_FREE    = 3'd0,
        ROLE_OPEN    = 3'd1,
        ROLE_FULL    = 3'd2,
        ROLE_VICTIM  = 3'd3,
        ROLE_COLLECT = 3'd4
    } t_role;

    typedef enum logic [2:0] {
        CMD_NOP     = 3'd0,
        CMD_INC     = 3'd1,
        CMD_DEC     = 3'd2,
        CMD_ROTATE  = 3'd3,
        CMD_COLLECT = 3'd4,
        CMD_RELEASE = 3'd5
    } t_cmd_kind;

    // Command broadcast to every cell
    typedef struct packed {
        t_cmd_kind          kind;
        logic [PAGE_W-1:0]  pps;
    } t_cmd;

    // Running best candidate handed from cell to cell
    typedef struct packed {
        logic               found;
        logic [PAGE_W-1:0]  valid;
    } t_scan;

    typedef enum logic [1:0] {
        OP_WRITE      = 2'd0,
        OP_INVALIDATE = 2'd1,
        OP_SELECT     = 2'd2,
        OP_RELEASE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_CAND = 2'd1,
        ST_BELOW   = 2'd2,
        ST_NO_FREE = 2'd3
    } t_status;

    localparam logic [1:0] REG_PPS    = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_URGENT = 2'd2;

    localparam logic [PAGE_W-1:0] PPS_RESET    = 16'd256;
    localparam logic [THR_W-1:0]  LOW_RESET    = 7'd16;
    localparam logic [THR_W-1:0]  URGENT_RESET = 7'd3;

endpackage

// ===== src/fsgc_cell.sv =====
// One segment cell: role, valid-page count and one stage of the victim scan.
module fsgc_cell #(
    parameter int IDW = 6,
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fsgc_pkg::t_cmd              i_cmd,
    input  logic [IDW-1:0]              i_id,
    input  logic [IDW-1:0]              i_new_id,
    input  fsgc_pkg::t_scan             i_scan,
    input  logic [IDW-1:0]              i_scan_id,
    output fsgc_pkg::t_scan             o_scan,
    output logic [IDW-1:0]              o_scan_id,
    output logic                        o_collect
);

    localparam logic [IDW-1:0] MY_ID = IDW'(IDX);

    fsgc_pkg::t_role                r_role, n_role;
    logic [fsgc_pkg::PAGE_W-1:0]    r_valid, n_valid;
    fsgc_pkg::t_scan                r_scan;
    logic [IDW-1:0]                 r_scan_id;
    logic                           w_hit;
    logic                           w_take;

    assign w_hit = (i_id == MY_ID);

    always_comb begin
        n_role  = r_role;
        n_valid = r_valid;
        case (i_cmd.kind)
            fsgc_pkg::CMD_INC: begin
                if (w_hit && r_valid != '1) begin
                    n_valid = r_valid + 1'b1;
                end
            end
            fsgc_pkg::CMD_DEC: begin
                if (w_hit && r_role != fsgc_pkg::ROLE_FREE && r_valid != '0) begin
                    n_valid = r_valid - 1'b1;
                    if (r_role == fsgc_pkg::ROLE_FULL) begin
                        n_role = fsgc_pkg::ROLE_VICTIM;
                    end
                end
            end
            fsgc_pkg::CMD_ROTATE: begin
                // close the old open segment, open the new one
                if (r_role == fsgc_pkg::ROLE_OPEN) begin
                    n_role = (r_valid >= i_cmd.pps) ? fsgc_pkg::ROLE_FULL
                                                    : fsgc_pkg::ROLE_VICTIM;
                end
                if (i_new_id == MY_ID) begin
                    n_role  = fsgc_pkg::ROLE_OPEN;
                    n_valid = '0;
                end
            end
            fsgc_pkg::CMD_COLLECT: begin
                if (w_hit) begin
                    n_role = fsgc_pkg::ROLE_COLLECT;
                end
            end
            fsgc_pkg::CMD_RELEASE: begin
                if (w_hit && r_role == fsgc_pkg::ROLE_COLLECT) begin
                    n_role  = fsgc_pkg::ROLE_FREE;
                    n_valid = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // strict compare keeps the lower id on ties
    assign w_take = (r_role == fsgc_pkg::ROLE_VICTIM) &&
                    (!i_scan.found || r_valid < i_scan.valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role     <= (IDX == 0) ? fsgc_pkg::ROLE_OPEN : fsgc_pkg::ROLE_FREE;
            r_valid    <= '0;
            r_scan     <= '0;
            r_scan_id  <= '0;
        end else begin
            r_role  <= n_role;
            r_valid <= n_valid;
            if (w_take) begin
                r_scan.found <= 1'b1;
                r_scan.valid <= r_valid;
                r_scan_id    <= MY_ID;
            end else begin
                r_scan    <= i_scan;
                r_scan_id <= i_scan_id;
            end
        end
    end

    assign o_scan    = r_scan;
    assign o_scan_id = r_scan_id;
    assign o_collect = (r_role == fsgc_pkg::ROLE_COLLECT);

endmodule

// ===== src/flash_segment_gc_manager.sv =====
// Top level: command sequencer, free-segment FIFO, config registers and the cell row.
// Segment bookkeeping for greedy garbage collection. A command is taken when start is
// high and busy is low; its single result appears on the o_ ports for exactly one cycle
// with o_valid high, and must be captured then. Invalidate and release pass through
// S_INV or S_REL and then S_RESP; a page write passes S_WPRE, S_WINC, S_WPOST and
// S_RESP (S_WPRE goes straight to S_RESP when no free segment can be taken before
// the write); victim select waits in S_SCAN for the scan wave that moves one cell
// per cycle along the row of segment cells, then S_SEL and S_RESP. After reset the
// free FIFO is loaded while busy is high; config writes are taken throughout.
module flash_segment_gc_manager #(
    parameter int NUM_SEGMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_segment_id,
    input  logic        i_force_req,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_segment_out,
    output logic [6:0]  o_free_count,
    output logic        o_gc_needed,
    output logic        o_gc_urgent,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDW = $clog2(NUM_SEGMENTS);
    localparam int FW  = $clog2(NUM_SEGMENTS + 1);
    localparam logic [IDW-1:0] LAST_ID = IDW'(NUM_SEGMENTS - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_WPRE, S_WINC, S_WPOST, S_INV, S_REL, S_SCAN, S_SEL, S_RESP
    } t_state;

    t_state                         r_state;
    logic [fsgc_pkg::PAGE_W-1:0]    r_pps;
    logic [fsgc_pkg::THR_W-1:0]     r_low;
    logic [fsgc_pkg::THR_W-1:0]     r_urgent;
    logic [IDW-1:0]                 r_head, r_tail, r_open, r_seg, r_sout, r_init;
    logic [FW-1:0]                  r_free, r_cnt;
    logic [fsgc_pkg::PAGE_W-1:0]    r_wp;
    logic                           r_seg_ok, r_force, r_sel_set;
    fsgc_pkg::t_status              r_status;
    logic [IDW-1:0]                 r_rd_data;
    logic [IDW-1:0]                 r_mem [NUM_SEGMENTS];

    fsgc_pkg::t_cmd                 w_cmd;
    logic [IDW-1:0]                 w_id;
    fsgc_pkg::t_scan                w_scan [NUM_SEGMENTS+1];
    logic [IDW-1:0]                 w_scan_id [NUM_SEGMENTS+1];
    logic [NUM_SEGMENTS-1:0]        w_collect;
    logic                           w_full_wp, w_can_pop, w_rel_ok, w_below, w_cfg_wr;
    logic [fsgc_pkg::PAGE_W-1:0]    w_invalid;

    function automatic logic [IDW-1:0] wrap_next(input logic [IDW-1:0] p);
        return (p == LAST_ID) ? '0 : p + 1'b1;
    endfunction

    assign w_full_wp = (r_wp >= r_pps);
    assign w_can_pop = (r_free != '0);
    assign w_rel_ok  = r_seg_ok && w_collect[r_seg] &&
                       (32'(r_free) < NUM_SEGMENTS);
    assign w_invalid = (r_pps > w_scan[NUM_SEGMENTS].valid)
                       ? r_pps - w_scan[NUM_SEGMENTS].valid : '0;
    assign w_below   = !r_force && (w_invalid < (r_pps >> 3));

    always_comb begin
        w_cmd.kind = fsgc_pkg::CMD_NOP;
        w_cmd.pps  = r_pps;
        w_id       = r_seg;
        case (r_state)
            S_WPRE, S_WPOST: begin
                if (w_full_wp && w_can_pop) begin
                    w_cmd.kind = fsgc_pkg::CMD_ROTATE;
                end
            end
            S_WINC: begin
                w_cmd.kind = fsgc_pkg::CMD_INC;
                w_id       = r_open;
            end
            S_INV: begin
                if (r_seg_ok) begin
                    w_cmd.kind = fsgc_pkg::CMD_DEC;
                end
            end
            S_REL: begin
                if (w_rel_ok) begin
                    w_cmd.kind = fsgc_pkg::CMD_RELEASE;
                end
            end
            S_SEL: begin
                w_id = w_scan_id[NUM_SEGMENTS];
                if (w_scan[NUM_SEGMENTS].found && !w_below) begin
                    w_cmd.kind = fsgc_pkg::CMD_COLLECT;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_scan[0]    = '0;
    assign w_scan_id[0] = '0;

    for (genvar g = 0; g < NUM_SEGMENTS; g++) begin : g_cell
        fsgc_cell #(
            .IDW (IDW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_id      (w_id),
            .i_new_id  (r_rd_data),
            .i_scan    (w_scan[g]),
            .i_scan_id (w_scan_id[g]),
            .o_scan    (w_scan[g+1]),
            .o_scan_id (w_scan_id[g+1]),
            .o_collect (w_collect[g])
        );
    end

    // free FIFO storage, head entry read into a register every cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT) begin
            r_mem[r_init] <= wrap_next(r_init);
        end else if (r_state == S_REL && w_rel_ok) begin
            r_mem[r_tail] <= r_seg;
        end
        r_rd_data <= r_mem[r_head];
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[3:2])
            fsgc_pkg::REG_PPS:    prdata = {16'd0, r_pps};
            fsgc_pkg::REG_LOW:    prdata = {25'd0, r_low};
            fsgc_pkg::REG_URGENT: prdata = {25'd0, r_urgent};
            default:              prdata = '0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_pps     <= fsgc_pkg::PPS_RESET;
            r_low     <= fsgc_pkg::LOW_RESET;
            r_urgent  <= fsgc_pkg::URGENT_RESET;
            r_head    <= '0;
            r_tail    <= LAST_ID;
            r_free    <= FW'(NUM_SEGMENTS - 1);
            r_open    <= '0;
            r_wp      <= '0;
            r_init    <= '0;
            r_cnt     <= '0;
            r_seg     <= '0;
            r_seg_ok  <= 1'b0;
            r_force   <= 1'b0;
            r_sel_set <= 1'b0;
            r_sout    <= '0;
            r_status  <= fsgc_pkg::ST_OK;
            o_valid   <= 1'b0;
            o_status  <= '0;
            o_segment_out <= '0;
            o_free_count  <= '0;
            o_gc_needed   <= 1'b0;
            o_gc_urgent   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    fsgc_pkg::REG_PPS:    r_pps    <= pwdata[15:0];
                    fsgc_pkg::REG_LOW:    r_low    <= pwdata[6:0];
                    fsgc_pkg::REG_URGENT: r_urgent <= pwdata[6:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_INIT: begin
                    r_init <= r_init + 1'b1;
                    if (r_init == LAST_ID) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_seg     <= IDW'(i_segment_id);
                        r_seg_ok  <= (32'(i_segment_id) < NUM_SEGMENTS);
                        r_force   <= i_force_req;
                        r_sel_set <= 1'b0;
                        r_status  <= fsgc_pkg::ST_OK;
                        r_cnt     <= FW'(NUM_SEGMENTS);
                        case (fsgc_pkg::t_op'(i_opcode))
                            fsgc_pkg::OP_WRITE:      r_state <= S_WPRE;
                            fsgc_pkg::OP_INVALIDATE: r_state <= S_INV;
                            fsgc_pkg::OP_SELECT:     r_state <= S_SCAN;
                            default:                 r_state <= S_REL;
                        endcase
                    end
                end
                S_WPRE: begin
                    r_state <= S_WINC;
                    if (w_full_wp) begin
                        if (!w_can_pop) begin
                            r_status <= fsgc_pkg::ST_NO_FREE;
                            r_state  <= S_RESP;
                        end else begin
                            r_head <= wrap_next(r_head);
                            r_free <= r_free - 1'b1;
                            r_open <= r_rd_data;
                            r_wp   <= '0;
                        end
                    end
                end
                S_WINC: begin
                    if (r_wp != '1) begin
                        r_wp <= r_wp + 1'b1;
                    end
                    r_state <= S_WPOST;
                end
                S_WPOST: begin
                    if (w_full_wp) begin
                        if (!w_can_pop) begin
                            r_status <= fsgc_pkg::ST_NO_FREE;
                        end else begin
                            r_head <= wrap_next(r_head);
                            r_free <= r_free - 1'b1;
                            r_open <= r_rd_data;
                            r_wp   <= '0;
                        end
                    end
                    r_state <= S_RESP;
                end
                S_INV: begin
                    r_state <= S_RESP;
                end
                S_REL: begin
                    if (w_rel_ok) begin
                        r_tail <= wrap_next(r_tail);
                        r_free <= r_free + 1'b1;
                    end else begin
                        r_status <= fsgc_pkg::ST_NO_CAND;
                    end
                    r_state <= S_RESP;
                end
                S_SCAN: begin
                    // wait for the scan wave to reach the end of the row
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == FW'(1)) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (!w_scan[NUM_SEGMENTS].found) begin
                        r_status <= fsgc_pkg::ST_NO_CAND;
                    end else begin
                        r_sel_set <= 1'b1;
                        r_sout    <= w_scan_id[NUM_SEGMENTS];
                        if (w_below) begin
                            r_status <= fsgc_pkg::ST_BELOW;
                        end
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    o_valid       <= 1'b1;
                    o_status      <= r_status;
                    o_segment_out <= r_sel_set ? 6'(r_sout) : 6'(r_open);
                    o_free_count  <= 7'(r_free);
                    o_gc_needed   <= (32'(r_free) <= 32'(r_low));
                    o_gc_urgent   <= (32'(r_free) <= 32'(r_urgent));
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
